FILE: hw/rtl/awm_pkg.sv
// ----------------------------------------------------------------------------
// awm_pkg: shared types and constants for the anagram window matcher
// Request kinds, pipeline op codes, result record and default sizes.
// ----------------------------------------------------------------------------
package awm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 1024;
    localparam int unsigned ALPHABET_DEF    = 26;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned LETTER_W = 5;

    // result queue; depth covers the pipeline depth for full rate
    localparam int unsigned RES_Q_DEPTH = 4;
    localparam int unsigned RES_Q_AW    = $clog2(RES_Q_DEPTH);
    localparam int unsigned RES_Q_CW    = $clog2(RES_Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    // op carried down the pipeline
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PATTERN,
        OP_TEXT,
        OP_EMPTY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic window_match;
        logic found;
    } res_t;

    typedef struct packed {
        logic vld;
        res_t data;
    } res_push_t;

endpackage

FILE: hw/rtl/awm_item_if.sv
// ----------------------------------------------------------------------------
// awm_item_if: request channel of the anagram window matcher
// valid/ready handshake carrying the request kind and letter.
// ----------------------------------------------------------------------------
interface awm_item_if;
    import awm_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output kind, output letter, input ready);
    modport sink   (input valid, input kind, input letter, output ready);
endinterface

FILE: hw/rtl/awm_result_if.sv
// ----------------------------------------------------------------------------
// awm_result_if: result channel of the anagram window matcher
// valid/ready handshake carrying the window match and sticky found flag.
// ----------------------------------------------------------------------------
interface awm_result_if;
    logic valid;
    logic ready;
    logic window_match;
    logic found;

    modport source (output valid, output window_match, output found, input ready);
    modport sink   (input valid, input window_match, input found, output ready);
endinterface

FILE: hw/rtl/anagram_window_matcher_unit.sv
// ----------------------------------------------------------------------------
// anagram_window_matcher_unit: sliding-window anagram search
// Reports, per text letter, whether the last pattern-length letters form a
// permutation of the loaded pattern, plus a sticky found flag.
// ----------------------------------------------------------------------------
// Usage:
//   item   : request channel. kind 0 loads a pattern letter, kind 1 streams a
//            text letter, kind 2 clears all state. Pattern and text letters
//            outside the alphabet and kind 3 are dropped. Pattern letters past
//            MAX_PATTERN are dropped.
//   result : one response per accepted text letter, none for other requests.
// Pipeline: the ring is read on the accepting edge, then the histograms are
//   read, then the histograms are updated and the response is written to
//   the queue.
// Throughput: one request per cycle while ready is high; the read-modify-write
//   of the histogram memories forwards the previous update.
// Stall: up to four responses are held in flight or queued; with the
//   receiver stalled, ready drops once four are outstanding.
// Reset: empty pattern, empty window, found cleared. Histogram entries come
//   out of reset through per-entry valid bits, so there is no clearing pass
// and the first request is taken right after reset. A clear request does
// the same.
// ----------------------------------------------------------------------------
module anagram_window_matcher_unit #(
    parameter int unsigned MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
    parameter int unsigned ALPHABET    = awm_pkg::ALPHABET_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    awm_item_if.sink     item,
    awm_result_if.source result
);
    import awm_pkg::*;

    localparam int unsigned RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned CNT_W   = $clog2(MAX_PATTERN + 1);
    localparam int unsigned HIST_AW = $clog2(ALPHABET);
    localparam int unsigned DIFF_W  = $clog2(ALPHABET + 1);

    localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_PATTERN);
    localparam logic [RING_AW:0]   RING_SPAN = (RING_AW + 1)'(MAX_PATTERN);
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(MAX_PATTERN - 1);

    // The window/pattern difference of a letter is kept as add - sub:
    //   add[x] counts text letters x entering the window,
    //   sub[x] counts pattern letters x and text letters x leaving it.
    // Each request then writes each memory at most once. Counters wrap; the
    // true difference stays within +-MAX_PATTERN, so zero test is exact.

    // ------------------------------------------------------------------
    // Stage 0: accept, window bookkeeping, ring access
    // ------------------------------------------------------------------
    op_t                 op0;
    logic                item_fire;
    logic                letter_ok;
    logic [HIST_AW-1:0]  letter_idx;
    logic                rem0;

    logic [CNT_W-1:0]    plen_reg, plen_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [RING_AW-1:0]  pos_reg, pos_next;
    logic [RING_AW-1:0]  fill_mod;
    logic [RING_AW-1:0]  oldest;
    logic [RING_AW:0]    oldest_wrap;
    logic [RES_Q_CW-1:0] cnt_reg, cnt_next;
    logic                res_pop;

    logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
    logic [LETTER_W-1:0] ring_rd_reg;

    assign item.ready = (cnt_reg < RES_Q_CW'(RES_Q_DEPTH));
    assign item_fire  = item.valid && item.ready;
    assign letter_ok  = (32'(item.letter) < ALPHABET);
    assign letter_idx = HIST_AW'(item.letter);
    assign res_pop    = result.valid && result.ready;

    always_comb
    begin
        op0 = OP_NONE;
        if (item_fire)
        begin
            case (item.kind)
                KIND_PATTERN:
                begin
                    if (letter_ok && (plen_reg < MAX_CNT))
                    begin
                        op0 = OP_PATTERN;
                    end
                end
                KIND_TEXT:
                begin
                    if (letter_ok)
                    begin
                        op0 = (plen_reg == '0) ? OP_EMPTY : OP_TEXT;
                    end
                end
                KIND_CLEAR:
                begin
                    op0 = OP_CLEAR;
                end
                default:
                begin
                    op0 = OP_NONE;
                end
            endcase
        end
    end

    // window full: the oldest letter drops out
    assign rem0 = (fill_reg >= plen_reg);

    // oldest slot = pos - fill, modulo ring size
    assign fill_mod    = (fill_reg == MAX_CNT) ? '0 : fill_reg[RING_AW-1:0];
    assign oldest_wrap = {1'b0, pos_reg} + RING_SPAN - {1'b0, fill_mod};
    assign oldest      = (pos_reg >= fill_mod) ? (pos_reg - fill_mod)
                                               : oldest_wrap[RING_AW-1:0];

    always_comb
    begin
        plen_next = plen_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        case (op0)
            OP_PATTERN:
            begin
                plen_next = plen_reg + 1'b1;
            end
            OP_TEXT:
            begin
                if (!rem0)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                pos_next = (pos_reg == RING_LAST) ? '0 : pos_reg + 1'b1;
            end
            OP_CLEAR:
            begin
                plen_next = '0;
                fill_next = '0;
                pos_next  = '0;
            end
            default:
            begin
                plen_next = plen_reg;
            end
        endcase
        // responses outstanding: in the pipeline or in the queue
        if ((op0 == OP_TEXT || op0 == OP_EMPTY) && !res_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!(op0 == OP_TEXT || op0 == OP_EMPTY) && res_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // history ring: read-before-write covers a full window of MAX_PATTERN
    always_ff @(posedge clk)
    begin
        ring_rd_reg <= ring_mem[oldest];
        if (op0 == OP_TEXT)
        begin
            ring_mem[pos_reg] <= item.letter;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: histogram reads at the leaving letter and the new letter
    // ------------------------------------------------------------------
    op_t                s1_op_reg;
    logic [HIST_AW-1:0] s1_letter_reg;
    logic               s1_rem_reg;
    logic [HIST_AW-1:0] gone1;

    logic [CNT_W-1:0]   add_mem [ALPHABET];
    logic [CNT_W-1:0]   sub_mem [ALPHABET];
    logic [CNT_W-1:0]   add_rd_g_reg, add_rd_l_reg;
    logic [CNT_W-1:0]   sub_rd_g_reg, sub_rd_l_reg;

    assign gone1 = HIST_AW'(ring_rd_reg);

    // ------------------------------------------------------------------
    // Stage 2: update histograms, differing count, found flag
    // ------------------------------------------------------------------
    op_t                s2_op_reg;
    logic [HIST_AW-1:0] s2_letter_reg;
    logic [HIST_AW-1:0] s2_gone_reg;
    logic               s2_rem_reg;

    logic [ALPHABET-1:0] add_vld_reg, add_vld_next;
    logic [ALPHABET-1:0] sub_vld_reg, sub_vld_next;

    // last write of each memory, for the read issued on the same edge
    logic               add_fw_vld_reg, sub_fw_vld_reg;
    logic [HIST_AW-1:0] add_fw_addr_reg, sub_fw_addr_reg;
    logic [CNT_W-1:0]   add_fw_data_reg, sub_fw_data_reg;

    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic               found_reg, found_next;

    logic [CNT_W-1:0]   a_g, a_l, b_g, b_l, d_g, d_l;
    logic [CNT_W-1:0]   l_after, g_after;
    logic               same_ltr, l_act, g_act;
    logic               l_up, l_dn, g_up, g_dn;
    logic               match;

    logic               add_we, sub_we;
    logic [HIST_AW-1:0] sub_wa;
    logic [CNT_W-1:0]   add_wd, sub_wd;
    res_push_t          push;

    function automatic logic [CNT_W-1:0] hist_pick(
        input logic               fw_vld,
        input logic [HIST_AW-1:0] fw_addr,
        input logic [CNT_W-1:0]   fw_data,
        input logic               ent_vld,
        input logic [HIST_AW-1:0] addr,
        input logic [CNT_W-1:0]   rd_data
    );
        logic [CNT_W-1:0] val;
        if (fw_vld && (fw_addr == addr))
        begin
            val = fw_data;
        end
        else if (ent_vld)
        begin
            val = rd_data;
        end
        else
        begin
            val = '0;
        end
        return val;
    endfunction

    always_comb
    begin
        a_g = hist_pick(add_fw_vld_reg, add_fw_addr_reg, add_fw_data_reg,
                        add_vld_reg[s2_gone_reg], s2_gone_reg, add_rd_g_reg);
        a_l = hist_pick(add_fw_vld_reg, add_fw_addr_reg, add_fw_data_reg,
                        add_vld_reg[s2_letter_reg], s2_letter_reg, add_rd_l_reg);
        b_g = hist_pick(sub_fw_vld_reg, sub_fw_addr_reg, sub_fw_data_reg,
                        sub_vld_reg[s2_gone_reg], s2_gone_reg, sub_rd_g_reg);
        b_l = hist_pick(sub_fw_vld_reg, sub_fw_addr_reg, sub_fw_data_reg,
                        sub_vld_reg[s2_letter_reg], s2_letter_reg, sub_rd_l_reg);
        d_g = a_g - b_g;
        d_l = a_l - b_l;

        same_ltr = (s2_gone_reg == s2_letter_reg);
        // leaving and entering the same letter cancel out
        l_act   = (s2_op_reg == OP_PATTERN) ||
                  ((s2_op_reg == OP_TEXT) && !(s2_rem_reg && same_ltr));
        g_act   = (s2_op_reg == OP_TEXT) && s2_rem_reg && !same_ltr;
        l_after = (s2_op_reg == OP_PATTERN) ? (d_l - 1'b1) : (d_l + 1'b1);
        g_after = d_g - 1'b1;

        l_up = l_act && (d_l == '0) && (l_after != '0);
        l_dn = l_act && (d_l != '0) && (l_after == '0);
        g_up = g_act && (d_g == '0) && (g_after != '0);
        g_dn = g_act && (d_g != '0) && (g_after == '0);

        add_we = (s2_op_reg == OP_TEXT);
        add_wd = a_l + 1'b1;
        sub_we = (s2_op_reg == OP_PATTERN) || ((s2_op_reg == OP_TEXT) && s2_rem_reg);
        sub_wa = (s2_op_reg == OP_PATTERN) ? s2_letter_reg : s2_gone_reg;
        sub_wd = ((s2_op_reg == OP_PATTERN) ? b_l : b_g) + 1'b1;
    end

    always_comb
    begin
        diff_next    = diff_reg;
        found_next   = found_reg;
        add_vld_next = add_vld_reg;
        sub_vld_next = sub_vld_reg;
        match        = 1'b0;
        push.vld     = 1'b0;
        case (s2_op_reg)
            OP_PATTERN:
            begin
                diff_next = diff_reg + DIFF_W'(l_up) - DIFF_W'(l_dn);
            end
            OP_TEXT:
            begin
                diff_next  = diff_reg + DIFF_W'(l_up) + DIFF_W'(g_up)
                                      - DIFF_W'(l_dn) - DIFF_W'(g_dn);
                match      = (diff_next == '0);
                found_next = found_reg || match;
                push.vld   = 1'b1;
            end
            OP_EMPTY:
            begin
                // empty pattern matches every window
                match      = 1'b1;
                found_next = 1'b1;
                push.vld   = 1'b1;
            end
            OP_CLEAR:
            begin
                diff_next    = '0;
                found_next   = 1'b0;
                add_vld_next = '0;
                sub_vld_next = '0;
            end
            default:
            begin
                diff_next = diff_reg;
            end
        endcase
        if (add_we)
        begin
            add_vld_next[s2_letter_reg] = 1'b1;
        end
        if (sub_we)
        begin
            sub_vld_next[sub_wa] = 1'b1;
        end
        push.data.window_match = match;
        push.data.found        = found_next;
    end

    // histogram memories: two reads, one write each
    always_ff @(posedge clk)
    begin
        add_rd_g_reg <= add_mem[gone1];
        add_rd_l_reg <= add_mem[s1_letter_reg];
        if (add_we)
        begin
            add_mem[s2_letter_reg] <= add_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_rd_g_reg <= sub_mem[gone1];
        sub_rd_l_reg <= sub_mem[s1_letter_reg];
        if (sub_we)
        begin
            sub_mem[sub_wa] <= sub_wd;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            s1_op_reg      <= OP_NONE;
            s2_op_reg      <= OP_NONE;
            add_vld_reg    <= '0;
            sub_vld_reg    <= '0;
            add_fw_vld_reg <= 1'b0;
            sub_fw_vld_reg <= 1'b0;
            diff_reg       <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            plen_reg       <= plen_next;
            fill_reg       <= fill_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            s1_op_reg      <= op0;
            s2_op_reg      <= s1_op_reg;
            add_vld_reg    <= add_vld_next;
            sub_vld_reg    <= sub_vld_next;
            add_fw_vld_reg <= add_we;
            sub_fw_vld_reg <= sub_we;
            diff_reg       <= diff_next;
            found_reg      <= found_next;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        s1_letter_reg   <= letter_idx;
        s1_rem_reg      <= rem0;
        s2_letter_reg   <= s1_letter_reg;
        s2_gone_reg     <= gone1;
        s2_rem_reg      <= s1_rem_reg;
        add_fw_addr_reg <= s2_letter_reg;
        add_fw_data_reg <= add_wd;
        sub_fw_addr_reg <= sub_wa;
        sub_fw_data_reg <= sub_wd;
    end

    awm_rslt_q u_rslt_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .result (result)
    );

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_Q_CW'(RES_Q_DEPTH))
        else $error("outstanding responses exceed queue depth");

    a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
        diff_reg <= DIFF_W'(ALPHABET))
        else $error("differing letter count exceeds alphabet size");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_op_reg == OP_CLEAR) |=>
            (diff_reg == '0 && !found_reg && add_vld_reg == '0 && sub_vld_reg == '0))
        else $error("clear did not reset histogram state");

    a_empty_found: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_op_reg == OP_EMPTY) |=> found_reg)
        else $error("empty pattern match did not set found");

    a_resp_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (cnt_reg != '0))
        else $error("response offered with no outstanding request");
`endif

endmodule

FILE: hw/rtl/awm_rslt_q.sv
// ----------------------------------------------------------------------------
// awm_rslt_q: result queue
// Small FIFO between the histogram pipeline and the result channel.
// ----------------------------------------------------------------------------
module awm_rslt_q (
    input  logic              clk,
    input  logic              rst_n,
    input  awm_pkg::res_push_t push,
    awm_result_if.source      result
);
    import awm_pkg::*;

    res_t                q_mem [RES_Q_DEPTH];
    logic [RES_Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_Q_CW-1:0] count_reg, count_next;
    logic                pop;

    assign pop = result.valid && result.ready;

    assign result.valid        = (count_reg != '0);
    assign result.window_match = q_mem[rd_ptr_reg].window_match;
    assign result.found        = q_mem[rd_ptr_reg].found;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.vld)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_Q_AW'(RES_Q_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_Q_AW'(RES_Q_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push.vld && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.vld && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.vld)
        begin
            q_mem[wr_ptr_reg] <= push.data;
        end
    end

endmodule

FILE: tb/anagram_window_matcher_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anagram_window_matcher_unit_test: self-checking bench for the anagram matcher
// Streams pattern, text, clear and junk requests through the request channel
// and checks every response against a cycle-free model of the histogram
// window. Directed cases come first, then random traffic under several
// idle/stall mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module anagram_window_matcher_unit_test;
    import awm_pkg::*;

    localparam int unsigned ALPHABET    = ALPHABET_DEF;
    localparam int unsigned MAX_PATTERN = MAX_PATTERN_DEF;

    // kind 3 has no meaning in the block; it must be dropped silently
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // watchdog bound on the run; the slowest legal run stays well under it
    localparam int CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;

    awm_item_if   item_bus ();
    awm_result_if result_bus ();

    anagram_window_matcher_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the matcher state
    // ------------------------------------------------------------------------
    logic [10:0]         pattern_count [ALPHABET];
    logic [10:0]         window_count  [ALPHABET];
    logic [LETTER_W-1:0] recent_letters [MAX_PATTERN];
    logic [9:0]          write_slot;      // ring slot for the next text letter
    logic [10:0]         pattern_len;
    logic [10:0]         window_len;      // text letters currently in the window
    logic [4:0]          unequal_letters; // letters whose two counts differ
    bit                  seen_hit;        // sticky found

    res_t awaited_answers [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_left;
    int mismatch_count;
    int cycle_count;

    function automatic void forget_everything();
        for (int i = 0; i < ALPHABET; i++)
        begin
            pattern_count[i] = '0;
            window_count[i]  = '0;
        end
        for (int i = 0; i < MAX_PATTERN; i++)
            recent_letters[i] = '0;
        write_slot      = '0;
        pattern_len     = '0;
        window_len      = '0;
        unequal_letters = '0;
        seen_hit        = 1'b0;
    endfunction

    // Bump one histogram entry and keep the count of unequal letters current.
    // Pattern entries only ever go up; window entries go both ways.
    function automatic void nudge_count(bit on_pattern, int idx, bit up);
        bit was_unequal;
        bit now_unequal;
        was_unequal = window_count[idx] != pattern_count[idx];
        if (on_pattern)
            pattern_count[idx] = pattern_count[idx] + 11'd1;
        else if (up)
            window_count[idx] = window_count[idx] + 11'd1;
        else if (window_count[idx] != 0)
            window_count[idx] = window_count[idx] - 11'd1;
        now_unequal = window_count[idx] != pattern_count[idx];
        if (was_unequal && !now_unequal)
            unequal_letters = unequal_letters - 5'd1;
        else if (!was_unequal && now_unequal)
            unequal_letters = unequal_letters + 5'd1;
    endfunction

    // Advance the shadow state by one accepted request and queue the
    // response it should produce, if any.
    function automatic void predict_window_answer(logic [KIND_W-1:0] kind,
                                                  logic [LETTER_W-1:0] letter);
        res_t        answer;
        logic [9:0]  oldest;
        logic [LETTER_W-1:0] leaving;
        if (kind == KIND_CLEAR)
        begin
            forget_everything();
            return;
        end
        if (kind == KIND_UNUSED || letter >= ALPHABET)
            return;
        if (kind == KIND_PATTERN)
        begin
            // letters past capacity are dropped
            if (pattern_len < MAX_PATTERN)
            begin
                nudge_count(1'b1, int'(letter), 1'b1);
                pattern_len = pattern_len + 11'd1;
            end
            return;
        end
        // text letter; an empty pattern matches anything and only sets the sticky flag
        if (pattern_len == 0)
        begin
            seen_hit = 1'b1;
            answer.window_match = 1'b1;
            answer.found        = 1'b1;
            awaited_answers.push_back(answer);
            return;
        end
        if (window_len >= pattern_len)
        begin
            // window full: the letter that slides out sits window_len slots back
            oldest  = write_slot - window_len[9:0];
            leaving = recent_letters[oldest];
            if (leaving < ALPHABET)
                nudge_count(1'b0, int'(leaving), 1'b0);
        end
        else
            window_len = window_len + 11'd1;
        nudge_count(1'b0, int'(letter), 1'b1);
        recent_letters[write_slot] = letter;
        write_slot = write_slot + 10'd1;
        answer.window_match = (unequal_letters == 0);
        if (answer.window_match)
            seen_hit = 1'b1;
        answer.found = seen_hit;
        awaited_answers.push_back(answer);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Response side: checks on every handshake, then picks next ready.
    // A nonzero hold-off keeps ready low until it has counted down, regardless of
    // the stall mix, so the block fills and backs up the request channel.
    // ------------------------------------------------------------------------
    initial
    begin
        res_t want;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch("response with nothing outstanding");
                else
                begin
                    want = awaited_answers.pop_front();
                    if (result_bus.window_match !== want.window_match)
                        report_mismatch($sformatf("window_match got %b want %b",
                                        result_bus.window_match, want.window_match));
                    if (result_bus.found !== want.found)
                        report_mismatch($sformatf("found got %b want %b",
                                        result_bus.found, want.found));
                end
            end
            if (hold_off_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Called just after the clock has risen; returns as the request
    // is taken, with valid still high so consecutive requests follow without
    // dropping valid in between.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [LETTER_W-1:0] letter);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid  <= 1'b1;
        item_bus.kind   <= kind;
        item_bus.letter <= letter;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        predict_window_answer(kind, letter);
    endtask

    // Drop valid and sit until every outstanding response is back. Always
    // waits on a clock edge first so valid is never lowered and raised in one step.
    task automatic wait_for_all_answers();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // nothing loaded yet: every text letter matches
    task automatic test_empty_pattern();
        send_request(KIND_TEXT, 5'd0);
        send_request(KIND_TEXT, 5'd25);
    endtask

    // pattern "abb", then windows sliding over matching and non-matching text
    task automatic test_permutation_window();
        send_request(KIND_PATTERN, 5'd0);
        send_request(KIND_PATTERN, 5'd1);
        send_request(KIND_PATTERN, 5'd1);
        send_request(KIND_TEXT, 5'd1);
        send_request(KIND_TEXT, 5'd0);
        send_request(KIND_TEXT, 5'd25);
        send_request(KIND_TEXT, 5'd1);
        send_request(KIND_TEXT, 5'd1);
        send_request(KIND_TEXT, 5'd0);
    endtask

    // pattern extended mid-stream; window keeps its letters and refills
    task automatic test_pattern_grows_after_text();
        send_request(KIND_CLEAR, 5'd0);
        send_request(KIND_PATTERN, 5'd2);
        send_request(KIND_TEXT, 5'd2);
        send_request(KIND_PATTERN, 5'd3);
        send_request(KIND_TEXT, 5'd3);
        send_request(KIND_TEXT, 5'd2);
    endtask

    // out-of-alphabet letters and kind 3 leave no trace
    task automatic test_ignored_requests();
        send_request(KIND_PATTERN, 5'd26);
        send_request(KIND_TEXT, 5'd31);
        send_request(KIND_UNUSED, 5'd5);
        send_request(KIND_TEXT, 5'd16);
    endtask

    // clear wipes pattern and sticky flag; next text sees an empty pattern
    task automatic test_clear();
        send_request(KIND_CLEAR, 5'd31);
        send_request(KIND_TEXT, 5'd7);
        wait_for_all_answers();
    endtask

    // Receiver goes dark for a long stretch while requests keep coming;
    // the block must fill, deassert ready, and lose nothing.
    task automatic test_receiver_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(KIND_CLEAR, 5'd0);
        send_request(KIND_PATTERN, 5'd4);
        send_request(KIND_PATTERN, 5'd5);
        hold_off_left = 300;
        repeat (40) send_request(KIND_TEXT, 5'd4 + 5'($urandom_range(1)));
        wait_for_all_answers();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly clear / pattern / text sequences drawn from a
    // narrow letter range so windows match often, with a sprinkling of junk,
    // mid-text pattern letters and stray clears. Dropped requests do not
    // count toward the quota.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int quota);
        int counted;
        int plen;
        int tlen;
        int span;
        int base;
        int roll;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        counted = 0;
        while (counted < quota)
        begin
            if ($urandom_range(99) < 88)
            begin
                send_request(KIND_CLEAR, LETTER_W'($urandom_range(31)));
                counted++;
            end
            roll = $urandom_range(99);
            if (roll < 8)
                plen = 0;
            else if (roll < 78)
                plen = $urandom_range(6, 1);
            else if (roll < 97)
                plen = $urandom_range(30, 7);
            else
                plen = $urandom_range(200, 40);
            span = ($urandom_range(99) < 15) ? ALPHABET : $urandom_range(4, 1);
            base = $urandom_range(ALPHABET - span);
            repeat (plen)
            begin
                send_request(KIND_PATTERN, LETTER_W'(base + $urandom_range(span - 1)));
                counted++;
            end
            tlen = $urandom_range(3 * plen + 10, plen + 2);
            repeat (tlen)
            begin
                roll = $urandom_range(199);
                if (roll < 3)
                    send_request(KIND_UNUSED, LETTER_W'($urandom_range(31)));
                else if (roll < 7)
                    send_request($urandom_range(1) ? KIND_TEXT : KIND_PATTERN,
                                 LETTER_W'($urandom_range(31, ALPHABET)));
                else if (roll < 10)
                begin
                    send_request(KIND_PATTERN,
                                 LETTER_W'(base + $urandom_range(span - 1)));
                    counted++;
                end
                else if (roll < 11)
                begin
                    send_request(KIND_CLEAR, LETTER_W'($urandom_range(31)));
                    counted++;
                end
                else
                begin
                    send_request(KIND_TEXT, LETTER_W'(base + $urandom_range(span - 1)));
                    counted++;
                end
            end
        end
        wait_for_all_answers();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count     = 0;
        hold_off_left      = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        forget_everything();

        rst_n           <= 1'b0;
        item_bus.valid  <= 1'b0;
        item_bus.kind   <= KIND_PATTERN;
        item_bus.letter <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_pattern();
        test_permutation_window();
        test_pattern_grows_after_text();
        test_ignored_requests();
        test_clear();

        test_random_traffic(0, 0, 450);
        test_receiver_hold_off();
        test_random_traffic(79, 0, 450);
        test_random_traffic(0, 79, 450);
        test_random_traffic(25, 25, 450);

        // let anything stray surface before judging
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
